/* rtl/extended_gcd_unit_defines.svh */
// Assertion macros for the extended GCD unit.
`ifndef EXTENDED_GCD_UNIT_DEFINES_SVH
`define EXTENDED_GCD_UNIT_DEFINES_SVH
// Implication checked at every edge outside reset.
`define EGCD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define EGCD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/egcd_pkg.sv */
// Package for the extended GCD unit: widths, controller states, and command and status structs.
package egcd_pkg;
    localparam int EGCD_WIDTH = 64;
    localparam int EGCD_FIELD = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_UPDATE,
        ST_OUT
    } egcd_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic mul_step;
        logic update;
    } egcd_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic rem_zero;
        logic div_done;
        logic mul_done;
    } egcd_stat_t;
endpackage

/* rtl/extended_gcd_unit.sv */
// Extended Euclidean GCD unit: gcd and Bezout coefficients of two operands.
//
// Input channel s_axis: one transaction carries operand_a (tdata low 64 bits)
// and operand_b (tdata high 64 bits); only the low WIDTH bits of each are used.
// Result channel m_axis: one transaction per input carrying divisor, coef_a
// and coef_b, with a*coef_a + b*coef_b = divisor. b zero gives a, 1, 0.
// Processing: one item at a time. Each Euclid step runs a bit-serial restoring
// divider and a bit-serial multiply of the quotient into both coefficients,
// plus a check state and an update state. An item ends with the output
// handshake; the number of steps is at most about 1.44*WIDTH.
// s_axis_tready is high only while idle. The result is held on m_axis until
// m_axis_tready; the next item is accepted in the cycle after that.
// Reset (aresetn low, synchronous) returns the controller to idle; no result
// is pending after reset.
module extended_gcd_unit #(
    parameter int WIDTH = egcd_pkg::EGCD_WIDTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // operand_a[63:0], operand_b[127:64]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata   // divisor[63:0], coef_a[127:64], coef_b[191:128]
);
    import egcd_pkg::*;

    egcd_cmd_t        cmd;
    egcd_stat_t       stat;
    logic [WIDTH-1:0] g;
    logic [WIDTH:0]   s, t;

    egcd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    egcd_datapath #(.WIDTH(WIDTH)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .in_a    (s_axis_tdata[WIDTH-1:0]),
        .in_b    (s_axis_tdata[EGCD_FIELD+WIDTH-1:EGCD_FIELD]),
        .res_g   (g),
        .res_s   (s),
        .res_t   (t)
    );

    // Coefficients are exact within WIDTH+1 bits; sign-extend to the field.
    assign m_axis_tdata = {EGCD_FIELD'($signed(t)), EGCD_FIELD'($signed(s)),
                           EGCD_FIELD'(g)};
endmodule

/* rtl/egcd_datapath.sv */
// Datapath: remainder and coefficient registers, bit-serial divider and multiplier.
module egcd_datapath #(
    parameter int WIDTH = egcd_pkg::EGCD_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  egcd_pkg::egcd_cmd_t    cmd,
    output egcd_pkg::egcd_stat_t   stat,
    input  logic [WIDTH-1:0]       in_a,
    input  logic [WIDTH-1:0]       in_b,
    output logic [WIDTH-1:0]       res_g,
    output logic [WIDTH:0]         res_s,
    output logic [WIDTH:0]         res_t
);
    import egcd_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_old_reg, rem_new_reg, quotient_reg, qrem_reg;
    logic [WIDTH:0]   sa_old_reg, sa_new_reg, sb_old_reg, sb_new_reg;
    logic [WIDTH:0]   pa_reg, pb_reg;
    logic [CW-1:0]    cnt_reg;

    // Restoring division, one quotient bit per cycle
    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] quotient_next, qrem_next;
    always_comb begin
        trial = {qrem_reg, quotient_reg[WIDTH-1]};
        if (trial >= {1'b0, rem_new_reg}) begin
            qrem_next     = WIDTH'(trial - {1'b0, rem_new_reg});
            quotient_next = {quotient_reg[WIDTH-2:0], 1'b1};
        end else begin
            qrem_next     = trial[WIDTH-1:0];
            quotient_next = {quotient_reg[WIDTH-2:0], 1'b0};
        end
    end

    // Shift-add multiply of q by both new coefficients, MSB first
    logic           qbit;
    logic [WIDTH:0] pa_next, pb_next;
    always_comb begin
        qbit    = quotient_reg[WIDTH-1];
        pa_next = {pa_reg[WIDTH-1:0], 1'b0} + (qbit ? sa_new_reg : '0);
        pb_next = {pb_reg[WIDTH-1:0], 1'b0} + (qbit ? sb_new_reg : '0);
    end

    // Bit counter: loaded for the divide, then reloaded for the multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start) begin
            cnt_reg <= CW'(WIDTH);
        end else if (cmd.div_step && cnt_reg == CW'(1)) begin
            cnt_reg <= CW'(WIDTH);
        end else if ((cmd.div_step || cmd.mul_step) && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_old_reg <= in_a;
            rem_new_reg <= in_b;
            sa_old_reg  <= (WIDTH+1)'(1);
            sa_new_reg  <= '0;
            sb_old_reg  <= '0;
            sb_new_reg  <= (WIDTH+1)'(1);
        end
        if (cmd.div_start) begin
            quotient_reg <= rem_old_reg;
            qrem_reg     <= '0;
            pa_reg       <= '0;
            pb_reg       <= '0;
        end else if (cmd.div_step) begin
            quotient_reg <= quotient_next;
            qrem_reg     <= qrem_next;
        end else if (cmd.mul_step) begin
            // rotate so the quotient is intact afterward
            quotient_reg <= {quotient_reg[WIDTH-2:0], quotient_reg[WIDTH-1]};
            pa_reg       <= pa_next;
            pb_reg       <= pb_next;
        end
        if (cmd.update) begin
            rem_old_reg <= rem_new_reg;
            rem_new_reg <= qrem_reg;
            sa_old_reg  <= sa_new_reg;
            sa_new_reg  <= sa_old_reg - pa_reg;
            sb_old_reg  <= sb_new_reg;
            sb_new_reg  <= sb_old_reg - pb_reg;
        end
    end

    assign stat.rem_zero = (rem_new_reg == '0);
    assign stat.div_done = (cnt_reg == CW'(1));
    assign stat.mul_done = (cnt_reg == CW'(1));
    assign res_g = rem_old_reg;
    assign res_s = sa_old_reg;
    assign res_t = sb_old_reg;
endmodule

/* rtl/egcd_ctrl.sv */
// Controller state machine sequencing the Euclid steps.
module egcd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output egcd_pkg::egcd_cmd_t  cmd,
    input  egcd_pkg::egcd_stat_t stat
);
    import egcd_pkg::*;

    egcd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.rem_zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (stat.mul_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

/* rtl/egcd_checker.sv */
// Port-level checker for the extended GCD unit, with its bind.
`include "extended_gcd_unit_defines.svh"
module egcd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata
);
    `EGCD_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "ready while result pending")
    `EGCD_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "accept did not start work")
    `EGCD_ASSERT_NXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
    `EGCD_ASSERT_NXT(a_idle_after_out, aclk, aresetn, m_axis_tvalid && m_axis_tready, s_axis_tready, "not idle after result")
endmodule

bind extended_gcd_unit egcd_checker u_egcd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
